FILE: rtl/core/hflc_pkg.sv
// Package for the HMM forward log column unit: constants, codes, states, log-add table builder.
`timescale 1ns / 1ps
`default_nettype none

package hflc_pkg;

	localparam int DEF_MAX_STATES   = 64;
	localparam int DEF_VALUE_BITS   = 32;
	localparam int DEF_LOGADD_DEPTH = 256;

	// Table spans d in [0, 16) in Q16, so d below 2^20 is looked up
	localparam int LA_SPAN_LOG2  = 4;
	localparam int LA_SPAN_BITS  = 16 + LA_SPAN_LOG2;
	localparam int LA_ENTRY_BITS = 17;
	localparam int Q31_SHIFT     = 31;

	localparam logic [1:0] REQ_TRANS = 2'd0;
	localparam logic [1:0] REQ_INIT  = 2'd1;
	localparam logic [1:0] REQ_EMIT  = 2'd2;

	typedef enum logic [2:0] {
		S_IDLE,
		S_READ,
		S_SUM,
		S_DIFF,
		S_SCALE,
		S_ACC,
		S_FINAL
	} state_t;

	// Shift-subtract division, elaboration only
	function automatic logic [63:0] udiv64(logic [63:0] num, logic [63:0] den);
		logic [64:0] rem;
		logic [63:0] q;
		rem = '0;
		q   = '0;
		for (int i = 63; i >= 0; i--) begin
			rem = {rem[63:0], num[i]};
			if (rem >= {1'b0, den}) begin
				rem  = rem - {1'b0, den};
				q[i] = 1'b1;
			end
		end
		return q;
	endfunction

	// log(1 + y), y in Q31, atanh series, rounded to Q16
	function automatic logic [LA_ENTRY_BITS-1:0] log1p_q16(logic [63:0] y);
		logic [63:0] z;
		logic [63:0] z2;
		logic [63:0] p;
		logic [63:0] sum;
		logic [63:0] res;
		z   = udiv64(y << Q31_SHIFT, (64'd1 << 32) + y);
		z2  = (z * z) >> Q31_SHIFT;
		p   = z;
		sum = '0;
		for (int n = 1; n <= 21; n += 2) begin
			sum = sum + udiv64(p, 64'(n));
			p   = (p * z2) >> Q31_SHIFT;
		end
		res = ((sum << 1) + (64'd1 << 14)) >> 15;
		return res[LA_ENTRY_BITS-1:0];
	endfunction

	// Entry idx holds log(1 + e^-(16 idx / depth)) in Q16
	function automatic logic [LA_ENTRY_BITS-1:0] logadd_entry(int depth, int idx);
		logic [63:0] t;
		logic [63:0] term;
		logic [63:0] y;
		logic [63:0] r;
		t    = udiv64(64'd1 << (Q31_SHIFT + LA_SPAN_LOG2), 64'(depth));
		term = 64'd1 << Q31_SHIFT;
		y    = 64'd1 << Q31_SHIFT;
		r    = 64'd1 << Q31_SHIFT;
		for (int n = 1; n <= 24; n++) begin
			term = udiv64((term * t) >> Q31_SHIFT, 64'(n));
			if ((n & 1) != 0) begin
				r = r - term;
			end else begin
				r = r + term;
			end
		end
		for (int i = 0; i < idx; i++) begin
			y = (y * r) >> Q31_SHIFT;
		end
		return log1p_q16(y);
	endfunction

endpackage

`default_nettype wire

FILE: rtl/core/hflc_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module hflc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64,
	localparam int ABITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [ABITS-1:0] wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic [ABITS-1:0] rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

`default_nettype wire

FILE: rtl/core/hflc_lut.sv
// Constant log(1 + e^-d) table for the log-add step.
`timescale 1ns / 1ps
`default_nettype none

module hflc_lut #(
	parameter int DEPTH = hflc_pkg::DEF_LOGADD_DEPTH,
	localparam int IB = $clog2(DEPTH)
) (
	input  logic [IB-1:0]                      idx,
	output logic [hflc_pkg::LA_ENTRY_BITS-1:0] entry
);

	import hflc_pkg::*;

	logic [LA_ENTRY_BITS-1:0] rom [DEPTH];

	for (genvar i = 0; i < DEPTH; i++) begin : g_rom
		localparam logic [LA_ENTRY_BITS-1:0] ENTRY = logadd_entry(DEPTH, i);
		assign rom[i] = ENTRY;
	end

	assign entry = rom[idx];

endmodule

`default_nettype wire

FILE: rtl/core/hmm_forward_log_column_unit.sv
// Log-space HMM forward column unit: sequencer, shared saturating adder, table and column RAMs.
// Load requests (transition or initial column entry) write their RAM when they are accepted.
// An emission request over a previous column of N states reads the RAMs and forms the sum for
// each state (RAM read, sum), runs a log-add (difference, scale, accumulate) for each live term
// after the first and then loads the result register; the next request is taken once the
// sequencer is back in idle. A stalled result holds the sequencer; no request is taken meanwhile.
// Reset clears the sequencer, column count, buffer select and result valid; RAMs are not cleared.
`timescale 1ns / 1ps
`default_nettype none

module hmm_forward_log_column_unit #(
	parameter int MAX_STATES         = hflc_pkg::DEF_MAX_STATES,
	parameter int VALUE_BITS         = hflc_pkg::DEF_VALUE_BITS,
	parameter int LOGADD_TABLE_DEPTH = hflc_pkg::DEF_LOGADD_DEPTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_stall,
	input  logic [1:0]         req_type,
	input  logic [5:0]         from_state,
	input  logic [5:0]         to_state,
	input  logic signed [31:0] log_value,
	input  logic               column_end,
	output logic               res_valid,
	input  logic               res_stall,
	output logic [5:0]         state_index,
	output logic signed [31:0] forward_value,
	output logic               column_done
);

	import hflc_pkg::*;

	localparam int IW = $clog2(MAX_STATES);
	localparam int CW = $clog2(MAX_STATES + 1);
	localparam int VB = VALUE_BITS;
	// headroom for sums of two values plus log-add growth
	localparam int AW = (VB < 20) ? 22 : VB + 2;
	// sums saturate to 64 bits; only reachable when AW exceeds 64
	localparam int SB = (AW > 64) ? 63 : AW - 1;
	localparam int OB = (VB < 32) ? VB : 32;
	localparam int IB = $clog2(LOGADD_TABLE_DEPTH);
	localparam int DB = $clog2(LOGADD_TABLE_DEPTH + 1);
	localparam int PW = LA_SPAN_BITS + DB;
	localparam int TRANS_DEPTH = MAX_STATES << IW;
	localparam int COL_DEPTH   = 2 << IW;

	localparam logic signed [64:0] VMAX65 = {{(66 - VB){1'b0}}, {(VB - 1){1'b1}}};
	localparam logic signed [64:0] VMIN65 = {{(66 - VB){1'b1}}, {(VB - 1){1'b0}}};
	localparam logic [VB-1:0]        VMIN_V  = {1'b1, {(VB - 1){1'b0}}};
	localparam logic signed [AW-1:0] VMIN_A  = {{(AW - VB + 1){1'b1}}, {(VB - 1){1'b0}}};
	localparam logic signed [AW-1:0] OMAX_A  = {{(AW - OB + 1){1'b0}}, {(OB - 1){1'b1}}};
	localparam logic signed [AW-1:0] OMIN_A  = {{(AW - OB + 1){1'b1}}, {(OB - 1){1'b0}}};

	state_t st_q, st_d;

	logic [CW-1:0] prev_count_q;
	logic          buf_sel_q;
	logic [CW-1:0] j_q;
	logic          have_q;
	logic          res_valid_q;

	logic [5:0]             to_q;
	logic [VB-1:0]          val_q;
	logic                   end_q;
	logic signed [AW-1:0]   acc_q;
	logic signed [AW-1:0]   s_q;
	logic signed [AW-1:0]   hi_q;
	logic [AW-1:0]          d_q;
	logic                   big_q;
	logic [IB-1:0]          idx_q;
	logic [5:0]             state_index_q;
	logic signed [31:0]     forward_value_q;
	logic                   column_done_q;

	logic accept, to_ok, from_ok, emit_go, trans_we, init_we, fin_go, step_last;
	logic [IW-1:0] to_idx_q;
	logic signed [64:0] lv_ext;
	logic [VB-1:0] in_val;

	logic [VB-1:0] tr_rd_data, col_rd_data;
	logic          col_we;
	logic [IW:0]   col_wr_addr;
	logic [VB-1:0] col_wr_data;
	logic signed [AW-1:0] p_ext, tr_ext, val_ext;
	logic skip;

	logic signed [AW-1:0] op_a, op_b, alu_raw, alu_top, alu_sat;
	logic                 op_sub;
	logic                 acc_gt;
	logic signed [AW-1:0] hi_sel, lo_sel;
	logic [LA_SPAN_BITS-1:0] d_lo;
	logic [PW-1:0]           prod;
	logic [LA_ENTRY_BITS-1:0] la_entry;
	logic signed [AW-1:0] res_pre, res_clamp;

	// ---------------- request decode ----------------
	assign req_stall = (st_q != S_IDLE);
	assign accept    = req_valid && !req_stall;
	assign to_ok     = ({26'd0, to_state} < 32'(MAX_STATES));
	assign from_ok   = ({26'd0, from_state} < 32'(MAX_STATES));
	assign emit_go   = accept && (req_type == REQ_EMIT) && to_ok;
	assign trans_we  = accept && (req_type == REQ_TRANS) && to_ok && from_ok;
	assign init_we   = accept && (req_type == REQ_INIT) && to_ok;

	// clamp the Q16.16 field into the value range; the most negative code is minus infinity
	assign lv_ext = 65'(log_value);
	always_comb begin
		if (log_value == 32'sh8000_0000) begin
			in_val = VMIN65[VB-1:0];
		end else if (lv_ext > VMAX65) begin
			in_val = VMAX65[VB-1:0];
		end else if (lv_ext < VMIN65) begin
			in_val = VMIN65[VB-1:0];
		end else begin
			in_val = lv_ext[VB-1:0];
		end
	end

	assign to_idx_q = IW'(to_q);

	// ---------------- memories ----------------
	hflc_ram #(
		.WIDTH (VB),
		.DEPTH (TRANS_DEPTH)
	) u_trans_ram (
		.clk     (clk),
		.wr_en   (trans_we),
		.wr_addr ({IW'(from_state), IW'(to_state)}),
		.wr_data (in_val),
		.rd_addr ({j_q[IW-1:0], to_idx_q}),
		.rd_data (tr_rd_data)
	);

	assign col_we      = init_we || fin_go;
	assign col_wr_addr = fin_go ? {~buf_sel_q, to_idx_q} : {buf_sel_q, IW'(to_state)};
	assign col_wr_data = fin_go ? res_clamp[VB-1:0] : in_val;

	hflc_ram #(
		.WIDTH (VB),
		.DEPTH (COL_DEPTH)
	) u_col_ram (
		.clk     (clk),
		.wr_en   (col_we),
		.wr_addr (col_wr_addr),
		.wr_data (col_wr_data),
		.rd_addr ({buf_sel_q, j_q[IW-1:0]}),
		.rd_data (col_rd_data)
	);

	hflc_lut #(
		.DEPTH (LOGADD_TABLE_DEPTH)
	) u_lut (
		.idx   (idx_q),
		.entry (la_entry)
	);

	assign p_ext   = AW'(signed'(col_rd_data));
	assign tr_ext  = AW'(signed'(tr_rd_data));
	assign val_ext = AW'(signed'(val_q));
	assign skip    = (col_rd_data == VMIN_V) || (tr_rd_data == VMIN_V);

	// ---------------- shared adder ----------------
	assign acc_gt = (acc_q > s_q);
	assign hi_sel = acc_gt ? acc_q : s_q;
	assign lo_sel = acc_gt ? s_q : acc_q;

	always_comb begin
		op_a   = '0;
		op_b   = '0;
		op_sub = 1'b0;
		case (st_q)
			S_SUM: begin
				op_a = p_ext;
				op_b = tr_ext;
			end
			S_DIFF: begin
				op_a   = hi_sel;
				op_b   = lo_sel;
				op_sub = 1'b1;
			end
			S_ACC: begin
				op_a = hi_q;
				op_b = AW'(la_entry);
			end
			S_FINAL: begin
				op_a = acc_q;
				op_b = val_ext;
			end
			default: begin
				op_a = '0;
			end
		endcase
	end

	assign alu_raw = op_a + (op_sub ? ~op_b : op_b) + AW'(op_sub);
	assign alu_top = alu_raw >>> SB;
	always_comb begin
		if ((alu_top != '0) && (alu_top != '1)) begin
			alu_sat = {{(AW - SB){alu_raw[AW-1]}}, {SB{~alu_raw[AW-1]}}};
		end else begin
			alu_sat = alu_raw;
		end
	end

	// table index = floor(d * depth / 16) with d in Q16
	assign d_lo = LA_SPAN_BITS'(d_q);
	assign prod = {{DB{1'b0}}, d_lo} * PW'(LOGADD_TABLE_DEPTH);

	// final result: minus infinity when nothing was live or the emission is minus infinity, then clamp to the output range
	assign res_pre = (!have_q || (val_q == VMIN_V)) ? VMIN_A : alu_sat;
	always_comb begin
		if (res_pre > OMAX_A) begin
			res_clamp = OMAX_A;
		end else if (res_pre < OMIN_A) begin
			res_clamp = OMIN_A;
		end else begin
			res_clamp = res_pre;
		end
	end

	// ---------------- sequencer ----------------
	assign step_last = ((j_q + CW'(1)) == prev_count_q);
	assign fin_go    = (st_q == S_FINAL) && (!res_valid_q || !res_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
		end else begin
			st_q <= st_d;
		end
	end

	always_comb begin
		st_d = st_q;
		unique case (st_q)
			S_IDLE: begin
				if (emit_go) begin
					st_d = (prev_count_q == '0) ? S_FINAL : S_READ;
				end
			end
			S_READ: begin
				st_d = S_SUM;
			end
			S_SUM: begin
				if (skip || !have_q) begin
					st_d = step_last ? S_FINAL : S_READ;
				end else begin
					st_d = S_DIFF;
				end
			end
			S_DIFF: begin
				st_d = S_SCALE;
			end
			S_SCALE: begin
				st_d = S_ACC;
			end
			S_ACC: begin
				st_d = step_last ? S_FINAL : S_READ;
			end
			S_FINAL: begin
				if (fin_go) begin
					st_d = S_IDLE;
				end
			end
			default: begin
				st_d = S_IDLE;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_count_q <= '0;
			buf_sel_q    <= 1'b0;
			j_q          <= '0;
			have_q       <= 1'b0;
			res_valid_q  <= 1'b0;
		end else begin
			if (init_we && column_end) begin
				prev_count_q <= CW'(to_state) + CW'(1);
			end
			if (fin_go && end_q) begin
				prev_count_q <= CW'(to_q) + CW'(1);
				buf_sel_q    <= ~buf_sel_q;
			end

			if (emit_go) begin
				j_q    <= '0;
				have_q <= 1'b0;
			end
			if ((st_q == S_SUM) && (skip || !have_q)) begin
				j_q <= j_q + CW'(1);
			end
			if ((st_q == S_SUM) && !skip) begin
				have_q <= 1'b1;
			end
			if (st_q == S_ACC) begin
				j_q <= j_q + CW'(1);
			end

			if (fin_go) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (emit_go) begin
			to_q  <= to_state;
			val_q <= in_val;
			end_q <= column_end;
		end
		case (st_q)
			S_SUM: begin
				s_q <= alu_sat;
				if (!skip && !have_q) begin
					acc_q <= alu_sat;
				end
			end
			S_DIFF: begin
				hi_q <= hi_sel;
				d_q  <= alu_raw;
			end
			S_SCALE: begin
				big_q <= ((d_q >> LA_SPAN_BITS) != '0);
				idx_q <= prod[LA_SPAN_BITS +: IB];
			end
			S_ACC: begin
				acc_q <= big_q ? hi_q : alu_sat;
			end
			default: begin
			end
		endcase
		if (fin_go) begin
			state_index_q   <= to_q;
			forward_value_q <= 32'(res_clamp);
			column_done_q   <= end_q;
		end
	end

	assign res_valid     = res_valid_q;
	assign state_index   = state_index_q;
	assign forward_value = forward_value_q;
	assign column_done   = column_done_q;

endmodule

`default_nettype wire
